// File: hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // hue wrap: bias makes every 16-bit angle positive, 6 * 5760
  localparam logic [16:0] HUE_BIAS    = 17'd34560;
  // 5760 = 45 * 128: floor(x / 45) = (x * 729) >> 15 for x < 526
  localparam logic [9:0]  HUE_RECIP45 = 10'd729;
  localparam logic [9:0]  HUE_DIV45   = 10'd45;
  // 960 = 15 * 64: floor(z / 15) = (z * 137) >> 11 for z < 90
  localparam logic [7:0]  SEC_RECIP15 = 8'd137;
  localparam logic [6:0]  SEC_DIV15   = 7'd15;
  // f = floor(rem * 4 / 15) = (rem * 17480) >> 16 for rem < 960
  localparam logic [14:0] FRAC_RECIP  = 15'd17480;
  // 255 * 256, the scale of q and t
  localparam logic [15:0] TERM_ONE    = 16'd65280;
  localparam logic [7:0]  UNIT_Q8     = 8'd255;
  localparam logic [8:0]  FRAC_ONE    = 9'd256;
  // floor(m / 255) = (m * 32897) >> 23 for m <= 65280
  localparam logic [15:0] RECIP255    = 16'd32897;

  localparam logic [7:0]  SAT_RESET   = 8'd204;
  localparam logic [7:0]  VAL_RESET   = 8'd255;

  // configuration register indexes
  localparam logic [0:0]  REG_SATURATION = 1'b0;
  localparam logic [0:0]  REG_VALUE      = 1'b1;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [7:0] frac;
  } frac_item_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } term_item_t;

endpackage

// File: hdl/hsv2rgb_hue_split.sv
module hsv2rgb_hue_split
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               hue_valid,
  input  logic signed [15:0] hue,
  output frac_item_t         item
);

  // stage 1: bias, split off 128s, quotient by 45
  logic [16:0] ubias;
  logic [18:0] qprod;
  logic        v1;
  logic [9:0]  x1;
  logic [6:0]  low1;
  logic [3:0]  quot1;

  assign ubias = {hue[15], hue} + HUE_BIAS;
  assign qprod = 19'(ubias[16:7]) * 19'(HUE_RECIP45);

  // stage 2: remainder by 45 -> wrapped hue, upper bits in units of 64/16 degree
  logic [9:0] y10;
  logic       v2;
  logic [6:0] z2;
  logic [5:0] lo2;

  assign y10 = x1 - 10'(quot1) * HUE_DIV45;

  // stage 3: sector
  logic [13:0] sprod;
  logic        v3;
  logic [2:0]  sec3;
  logic [6:0]  z3;
  logic [5:0]  lo3;

  assign sprod = 14'(z2) * 14'(SEC_RECIP15);

  // stage 4: remainder inside sector
  logic [6:0] d7;
  logic       v4;
  logic [2:0] sec4;
  logic [9:0] rem4;

  assign d7 = z3 - 7'(sec3) * SEC_DIV15;

  // stage 5: 8-bit fraction
  logic [24:0] fprod;
  logic        v5;
  logic [2:0]  sec5;
  logic [7:0]  frac5;

  assign fprod = 25'(rem4) * 25'(FRAC_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= hue_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= ubias[16:7];
      low1  <= ubias[6:0];
      quot1 <= qprod[18:15];
      z2    <= {y10[5:0], low1[6]};
      lo2   <= low1[5:0];
      sec3  <= sprod[13:11];
      z3    <= z2;
      lo3   <= lo2;
      sec4  <= sec3;
      rem4  <= {d7[3:0], lo3};
      sec5  <= sec4;
      frac5 <= fprod[23:16];
    end
  end

  assign item.valid  = v5;
  assign item.sector = sector_t'(sec5);
  assign item.frac   = frac5;

endmodule

// File: hdl/hsv2rgb_terms.sv
module hsv2rgb_terms
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  frac_item_t fin,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output term_item_t tout
);

  // stage 6: f*s, (1-f)*s, v*(1-s)
  logic        v6;
  sector_t     sec6;
  logic [15:0] fs6;
  logic [15:0] fts6;
  logic [15:0] pn6;
  logic [8:0]  finv;

  assign finv = FRAC_ONE - 9'(fin.frac);

  // stage 7: v * (one - x), 24 bits
  logic        v7;
  sector_t     sec7;
  logic [23:0] nq7;
  logic [23:0] nt7;
  logic [15:0] pn7;

  // stage 8: q, t divide by 65280 = >>8 then reciprocal of 255; p by 255 only
  logic [31:0] qprod;
  logic [31:0] tprod;
  logic [31:0] pprod;
  logic        v8;
  sector_t     sec8;
  logic [7:0]  p8;
  logic [7:0]  q8;
  logic [7:0]  t8;

  assign qprod = 32'(nq7[23:8]) * 32'(RECIP255);
  assign tprod = 32'(nt7[23:8]) * 32'(RECIP255);
  assign pprod = 32'(pn7) * 32'(RECIP255);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v6 <= fin.valid;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec6 <= fin.sector;
      fs6  <= 16'(fin.frac) * 16'(sat);
      fts6 <= 16'(17'(finv) * 17'(sat));
      pn6  <= 16'(val) * 16'(UNIT_Q8 - sat);
      sec7 <= sec6;
      nq7  <= 24'(val) * 24'(TERM_ONE - fs6);
      nt7  <= 24'(val) * 24'(TERM_ONE - fts6);
      pn7  <= pn6;
      sec8 <= sec7;
      q8   <= qprod[30:23];
      t8   <= tprod[30:23];
      p8   <= pprod[30:23];
    end
  end

  assign tout.valid  = v8;
  assign tout.sector = sec8;
  assign tout.p      = p8;
  assign tout.q      = q8;
  assign tout.t      = t8;

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// Each accepted hue item passes 8 stages and the output register to become its RGB item.
// Throughput: one item per cycle when not stalled; all stages advance together whenever the
// output register is empty or being taken, so a stall only holds, never drops an item.
// Reset (rst, synchronous, active high): all valid bits clear, saturation = 204,
// brightness_value = 255.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // hue channel
  input  logic               hue_valid,
  output logic               hue_stall,
  input  logic signed [15:0] hue,
  // rgb channel
  output logic               rgb_valid,
  input  logic               rgb_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  // configuration writes
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // Q0.8 config, 255 means 1.0
  logic [7:0] saturation;
  logic [7:0] brightness_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation       <= SAT_RESET;
      brightness_value <= VAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SATURATION: saturation       <= cfg_data;
        REG_VALUE:      brightness_value <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Pipeline moves as one: hold only while a finished item waits and is stalled.
  // Bubbles move forward too, since every stage shares the same enable.
  logic advance;
  assign advance   = !rgb_valid || !rgb_stall;
  assign hue_stall = !advance;

  // stages 1-5: wrap hue mod 360 deg, sector and 8-bit fraction
  frac_item_t frac_item;

  hsv2rgb_hue_split u_split (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .hue_valid (hue_valid),
    .hue       (hue),
    .item      (frac_item)
  );

  // stages 6-8: p, q, t, each truncated once
  term_item_t term_item;

  hsv2rgb_terms u_terms (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .fin  (frac_item),
    .sat  (saturation),
    .val  (brightness_value),
    .tout (term_item)
  );

  // output register: route v/p/q/t to channels by sector
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  always_comb begin
    unique case (term_item.sector)
      SEC_RED_YELLOW: begin
        red_next   = brightness_value;
        green_next = term_item.t;
        blue_next  = term_item.p;
      end
      SEC_YELLOW_GREEN: begin
        red_next   = term_item.q;
        green_next = brightness_value;
        blue_next  = term_item.p;
      end
      SEC_GREEN_CYAN: begin
        red_next   = term_item.p;
        green_next = brightness_value;
        blue_next  = term_item.t;
      end
      SEC_CYAN_BLUE: begin
        red_next   = term_item.p;
        green_next = term_item.q;
        blue_next  = brightness_value;
      end
      SEC_BLUE_MAGENTA: begin
        red_next   = term_item.t;
        green_next = term_item.p;
        blue_next  = brightness_value;
      end
      default: begin
        red_next   = brightness_value;
        green_next = term_item.p;
        blue_next  = term_item.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (advance) begin
      rgb_valid <= term_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term_item.valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

// File: hdl/hsv2rgb_checker.sv
module hsv2rgb_checker (
  input logic               clk,
  input logic               rst,
  input logic               hue_valid,
  input logic               hue_stall,
  input logic signed [15:0] hue,
  input logic               rgb_valid,
  input logic               rgb_stall,
  input logic [7:0]         red,
  input logic [7:0]         green,
  input logic [7:0]         blue
);

  // a stalled rgb item holds its payload
  a_rgb_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && rgb_stall |=> rgb_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("rgb item changed while stalled");

  // a stalled hue item stays offered unchanged
  a_hue_hold: assert property (@(posedge clk) disable iff (rst)
    hue_valid && hue_stall |=> hue_valid && $stable(hue))
    else $error("hue item changed while stalled");

  // input backpressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk)
    hue_stall |-> rgb_valid && rgb_stall)
    else $error("hue stalled without output backpressure");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rgb_valid)
    else $error("rgb_valid set right after reset");

  // an item leaves only through a handshake
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(rgb_valid) |-> $past(!rgb_stall))
    else $error("rgb item dropped while stalled");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .hue_valid (hue_valid),
  .hue_stall (hue_stall),
  .hue       (hue),
  .rgb_valid (rgb_valid),
  .rgb_stall (rgb_stall),
  .red       (red),
  .green     (green),
  .blue      (blue)
);
